@@ design/psf_pkg.sv @@
// shared types and constants for the preamble strip framer
package psf_pkg;

	localparam int BYTE_W    = 8;
	localparam int PLEN_W    = 5;
	localparam int FLEN_W    = 16;
	localparam int PAT_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	// startup fill counter saturates here
	localparam logic [PLEN_W-1:0] FILL_CAP = 5'd16;

	// value the window is cleared to
	localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

	// reset values of the configuration registers
	localparam logic [PLEN_W-1:0] PLEN_RST = 5'd4;
	localparam logic [FLEN_W-1:0] FLEN_RST = 16'd64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd3;

	typedef enum logic [1:0] {
		PH_FILL    = 2'd0,
		PH_SEARCH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              frame_end;
	} result_t;

endpackage

@@ design/psf_match.sv @@
// parallel compare of the sliding window against the configured preamble
module psf_match #(
	parameter int MAX_PREAMBLE = 16
) (
	input  logic [MAX_PREAMBLE-1:0][psf_pkg::BYTE_W-1:0] window,
	input  logic [psf_pkg::PAT_W-1:0]                    pattern_low,
	input  logic [psf_pkg::PAT_W-1:0]                    pattern_high,
	input  logic [psf_pkg::PLEN_W-1:0]                   plen,
	output logic                                         match
);
	import psf_pkg::*;

	logic [MAX_PREAMBLE-1:0] byte_ok;

	// one comparator per window byte, bytes past plen always pass
	for (genvar gi = 0; gi < MAX_PREAMBLE; gi++) begin : g_cmp
		logic [BYTE_W-1:0] pat_byte;
		if (gi < 8) begin : g_lo
			assign pat_byte = pattern_low[BYTE_W*gi +: BYTE_W];
		end else begin : g_hi
			assign pat_byte = pattern_high[BYTE_W*(gi-8) +: BYTE_W];
		end
		assign byte_ok[gi] = (PLEN_W'(gi) >= plen) || (window[gi] == pat_byte);
	end

	assign match = &byte_ok;

endmodule

@@ design/psf_out_reg.sv @@
// output register for result beats
module psf_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  psf_pkg::result_t            result,
	output logic                        free,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [psf_pkg::BYTE_W-1:0]  m_axis_tdata,  // out_byte
	output logic                        m_axis_tlast   // frame_end
);
	import psf_pkg::*;

	logic    valid_q;
	result_t data_q;

	// slot can take a beat when empty or draining this cycle
	assign free = !valid_q || m_axis_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q.out_byte;
	assign m_axis_tlast  = data_q.frame_end;

endmodule

@@ design/preamble_strip_framer_top.sv @@
// preamble strip framer: window correlator, frame sync and payload output
// a result passes through the input stage and the output register before it is on m_axis
// one byte per cycle unless m_axis stalls, set by the single input stage and output register
// the state update for a byte is combinational between these two registers
// reset: arst_n clears all control state, window to 0xFF, startup fill mode
// reset config: preamble_len 4, frame_len 64, both pattern words 0
module preamble_strip_framer_top #(
	parameter int MAX_PREAMBLE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [psf_pkg::BYTE_W-1:0]     s_axis_tdata,   // data_byte
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [psf_pkg::BYTE_W-1:0]     m_axis_tdata,   // out_byte
	output logic                           m_axis_tlast    // frame_end
);
	import psf_pkg::*;

	localparam int WIN_IDX_W = (MAX_PREAMBLE > 1) ? $clog2(MAX_PREAMBLE) : 1;

	// configuration registers
	logic [PLEN_W-1:0] preamble_len_q;
	logic [FLEN_W-1:0] frame_len_q;
	logic [PAT_W-1:0]  pattern_low_q;
	logic [PAT_W-1:0]  pattern_high_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// framer state
	logic [MAX_PREAMBLE-1:0][BYTE_W-1:0] window_q, window_d, window_up;
	phase_t            phase_q, phase_d;
	logic [PLEN_W-1:0] fill_count_q, fill_count_d, fill_inc;
	logic [FLEN_W-1:0] payload_count_q, payload_count_d;

	logic              out_free, adv, match, produce;
	logic [PLEN_W-1:0] plen;
	logic [FLEN_W-1:0] pay_len, pc_base;
	logic [FLEN_W:0]   cnt;
	logic              last;
	result_t           result;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_len_q <= PLEN_RST;
			frame_len_q    <= FLEN_RST;
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PREAMBLE_LEN: preamble_len_q <= cfg_data[PLEN_W-1:0];
				REG_FRAME_LEN:    frame_len_q    <= cfg_data[FLEN_W-1:0];
				REG_PATTERN_LOW:  pattern_low_q  <= cfg_data[PAT_W-1:0];
				REG_PATTERN_HIGH: pattern_high_q <= cfg_data[PAT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective preamble length, clamped to 1..MAX_PREAMBLE
	always_comb begin
		if (preamble_len_q == '0) begin
			plen = PLEN_W'(1);
		end else if (preamble_len_q > PLEN_W'(MAX_PREAMBLE)) begin
			plen = PLEN_W'(MAX_PREAMBLE);
		end else begin
			plen = preamble_len_q;
		end
	end

	// payload length, short frames give one byte
	assign pay_len = (frame_len_q > FLEN_W'(plen)) ? (frame_len_q - FLEN_W'(plen))
	                                               : FLEN_W'(1);

	// handshake: input stage advances when the output slot is free
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	psf_match #(
		.MAX_PREAMBLE(MAX_PREAMBLE)
	) u_match (
		.window      (window_q),
		.pattern_low (pattern_low_q),
		.pattern_high(pattern_high_q),
		.plen        (plen),
		.match       (match)
	);

	// window shifted down by one, new byte at the top
	for (genvar gi = 0; gi < MAX_PREAMBLE; gi++) begin : g_up
		if (gi < MAX_PREAMBLE - 1) begin : g_mid
			assign window_up[gi] = window_q[gi+1];
		end else begin : g_top
			assign window_up[gi] = byte_s1;
		end
	end

	// payload counter compare, starts from zero when a match opens the frame
	assign pc_base  = (phase_q == PH_PAYLOAD) ? payload_count_q : '0;
	assign cnt      = {1'b0, pc_base} + (FLEN_W+1)'(1);
	assign last     = cnt >= {1'b0, pay_len};
	assign fill_inc = (fill_count_q < FILL_CAP) ? (fill_count_q + PLEN_W'(1)) : fill_count_q;

	// byte produces a result in payload mode or on a window match
	always_comb begin
		case (phase_q)
			PH_FILL:    produce = 1'b0;
			PH_PAYLOAD: produce = 1'b1;
			default:    produce = match;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_FILL: begin
				if (fill_inc >= plen) begin
					phase_d = PH_SEARCH;
				end
			end
			default: begin
				if (produce) begin
					phase_d = last ? PH_SEARCH : PH_PAYLOAD;
				end else begin
					phase_d = PH_SEARCH;
				end
			end
		endcase
	end

	// window and counter updates
	always_comb begin
		window_d        = window_q;
		fill_count_d    = fill_count_q;
		payload_count_d = payload_count_q;
		case (phase_q)
			PH_FILL: begin
				window_d[fill_count_q[WIN_IDX_W-1:0]] = byte_s1;
				fill_count_d = fill_inc;
			end
			default: begin
				if (produce) begin
					if (last) begin
						payload_count_d = '0;
						window_d        = {MAX_PREAMBLE{FILL_BYTE}};
					end else begin
						payload_count_d = cnt[FLEN_W-1:0];
					end
				end else begin
					for (int i = 0; i < MAX_PREAMBLE; i++) begin
						if (PLEN_W'(i) + PLEN_W'(1) < plen) begin
							window_d[i] = window_up[i];
						end else if (PLEN_W'(i) == plen - PLEN_W'(1)) begin
							window_d[i] = byte_s1;
						end
					end
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q        <= {MAX_PREAMBLE{FILL_BYTE}};
			phase_q         <= PH_FILL;
			fill_count_q    <= '0;
			payload_count_q <= '0;
		end else if (adv) begin
			window_q        <= window_d;
			phase_q         <= phase_d;
			fill_count_q    <= fill_count_d;
			payload_count_q <= payload_count_d;
		end
	end

	assign result.out_byte  = byte_s1;
	assign result.frame_end = last;

	psf_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv && produce),
		.result       (result),
		.free         (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

`ifndef SYNTHESIS
	// a frame end returns to search with a cleared window
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && produce && last) |=> (phase_q == PH_SEARCH && window_q[0] == FILL_BYTE))
		else $error("frame end did not clear window");

	// no result during startup fill
	a_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_FILL) |=> !(m_axis_tvalid && !$past(m_axis_tvalid)))
		else $error("result produced during startup fill");

	// inside a frame at least one payload byte has been produced
	a_payload_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (payload_count_q != '0))
		else $error("payload phase with zero count");
`endif

endmodule

@@ sim/preamble_strip_framer_top_test.sv @@
// self-checking testbench for the preamble strip framer: directed and random byte streams
module preamble_strip_framer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import psf_pkg::*;

	localparam int          MAX_PRE      = 16;
	localparam int          RESET_CYCLES = 11;
	localparam int          DRAIN        = 8;
	localparam int          HOLD_CYCLES  = 150;
	localparam int          PAYLOAD_CAP  = 40;
	localparam logic [15:0] RX_PATTERN   = 16'b1101_1001_1110_0110;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [BYTE_W-1:0]    s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [BYTE_W-1:0]    m_axis_tdata;
	logic                 m_axis_tlast;

	preamble_strip_framer_top #(
		.MAX_PREAMBLE(MAX_PRE)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// framer state as the testbench sees it
	logic [BYTE_W-1:0] corr_window [16] = '{default: FILL_BYTE};
	phase_t            sync_phase       = PH_FILL;
	logic [PLEN_W-1:0] fill_cnt         = '0;
	logic [FLEN_W-1:0] payload_cnt      = '0;

	// shadow of the configuration registers
	logic [PLEN_W-1:0] preamble_len_reg = PLEN_RST;
	logic [FLEN_W-1:0] frame_len_reg    = FLEN_RST;
	logic [PAT_W-1:0]  pattern_low_reg  = '0;
	logic [PAT_W-1:0]  pattern_high_reg = '0;

	result_t     payload_due [$];
	int unsigned errors      = 0;
	int unsigned bytes_sent  = 0;
	int unsigned burst_left  = 0;
	bit          gaps_on     = 1'b0;
	int unsigned rx_mode     = 0;
	int unsigned holds_asked = 0;

	// preamble length in use: 0 acts as 1, large values clamp
	function automatic int unsigned plen_of(input logic [PLEN_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_PRE)
			return MAX_PRE;
		return w;
	endfunction

	function automatic logic [BYTE_W-1:0] preamble_byte(input int unsigned i);
		return (i < 8) ? pattern_low_reg[8*i +: 8] : pattern_high_reg[8*(i-8) +: 8];
	endfunction

	// payload bytes per frame under the current settings
	function automatic int unsigned payload_len();
		int unsigned eff;
		eff = plen_of(preamble_len_reg);
		return (frame_len_reg > eff) ? frame_len_reg - eff : 1;
	endfunction

	// advance the framer by one byte, queue the payload beat it produces
	function automatic void predict_payload(input logic [BYTE_W-1:0] b);
		int unsigned eff;
		int unsigned cnt;
		bit          hit;
		result_t     r;
		eff = plen_of(preamble_len_reg);
		if (sync_phase == PH_FILL) begin
			corr_window[fill_cnt[3:0]] = b;
			if (fill_cnt < FILL_CAP)
				fill_cnt++;
			if (fill_cnt >= eff)
				sync_phase = PH_SEARCH;
			return;
		end
		// window compare happens before the byte shifts in
		if (sync_phase != PH_PAYLOAD) begin
			hit = 1'b1;
			for (int i = 0; i < eff; i++)
				if (corr_window[i] != preamble_byte(i))
					hit = 1'b0;
			if (!hit) begin
				for (int i = 0; i + 1 < eff; i++)
					corr_window[i] = corr_window[i+1];
				corr_window[eff-1] = b;
				sync_phase = PH_SEARCH;
				return;
			end
			sync_phase  = PH_PAYLOAD;
			payload_cnt = '0;
		end
		cnt        = payload_cnt + 1;
		r.out_byte = b;
		if (cnt >= payload_len()) begin
			r.frame_end = 1'b1;
			payload_cnt = '0;
			corr_window = '{default: FILL_BYTE};
			sync_phase  = PH_SEARCH;
		end else begin
			r.frame_end = 1'b0;
			payload_cnt = cnt[FLEN_W-1:0];
		end
		payload_due.push_back(r);
	endfunction

	// offer one byte, bursts separated by random gaps when enabled
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		predict_payload(b);
	endtask

	// stop offering and wait until every payload beat is out
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (payload_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PREAMBLE_LEN: preamble_len_reg = val[PLEN_W-1:0];
			REG_FRAME_LEN:    frame_len_reg    = val[FLEN_W-1:0];
			REG_PATTERN_LOW:  pattern_low_reg  = val;
			REG_PATTERN_HIGH: pattern_high_reg = val;
			default: ;
		endcase
	endtask

	// continue any open frame (up to PAYLOAD_CAP bytes), then preamble (optionally corrupted) and payload
	task automatic send_frame(input bit broken);
		int unsigned eff;
		int unsigned rem;
		int unsigned bad_at;
		logic [BYTE_W-1:0] b;
		eff = plen_of(preamble_len_reg);
		if (sync_phase == PH_PAYLOAD) begin
			rem = (payload_len() > payload_cnt) ? payload_len() - payload_cnt : 1;
			if (rem > PAYLOAD_CAP)
				rem = PAYLOAD_CAP;
			repeat (rem) send_byte(8'($urandom));
		end
		bad_at = broken ? $urandom_range(0, eff - 1) : eff;
		for (int i = 0; i < eff; i++) begin
			b = preamble_byte(i);
			if (i == bad_at)
				b ^= 8'(1 << $urandom_range(0, 7));
			send_byte(b);
		end
		if (broken)
			rem = $urandom_range(0, 3);
		else
			rem = payload_len() + (($urandom_range(0, 7) == 0) ? 1 : 0);
		if (rem > PAYLOAD_CAP)
			rem = PAYLOAD_CAP;
		repeat (rem) send_byte(8'($urandom));
	endtask

	// length change during startup fill, then frame length change mid-frame
	task automatic test_startup_fill();
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();
		write_reg(REG_PREAMBLE_LEN, '0);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h55);
		settle();
		write_reg(REG_FRAME_LEN, 64'd2);
		send_byte(8'hAA);
		settle();
	endtask

	// one-byte payloads, including a preamble equal to the cleared window
	task automatic test_short_frames();
		write_reg(REG_FRAME_LEN, '0);
		write_reg(REG_PATTERN_LOW, 64'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'hFE);
		settle();
		write_reg(REG_FRAME_LEN, 64'd1);
		write_reg(REG_PATTERN_LOW, '0);
		send_byte(8'h33);
		send_byte(8'h00);
		send_byte(8'hC3);
		settle();
	endtask

	// receiver holds off long enough that the input side backs up
	task automatic test_output_hold();
		write_reg(REG_PREAMBLE_LEN, 64'd3);
		write_reg(REG_FRAME_LEN, 64'd33);
		write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
		gaps_on = 1'b0;
		rx_mode = 0;
		holds_asked++;
		repeat (3) send_frame(1'b0);
		settle();
	endtask

	// several settings, mostly well-formed frames with noise and broken preambles
	task automatic test_random_frames();
		logic [PLEN_W-1:0] plen_w;
		logic [FLEN_W-1:0] flen_w;
		int unsigned       eff;
		int unsigned       stop_at;
		int unsigned       pick;
		for (int p = 0; p < 10; p++) begin
			case (p)
				0:       plen_w = 5'd1;
				1:       plen_w = 5'd16;
				2:       plen_w = 5'd31;
				3:       plen_w = 5'd0;
				4:       plen_w = 5'd17;
				default: plen_w = PLEN_W'($urandom_range(2, 15));
			endcase
			eff = plen_of(plen_w);
			case (p)
				6:       flen_w = '1;
				7:       flen_w = '0;
				default: begin
					case ($urandom_range(0, 4))
						0:       flen_w = FLEN_W'(eff);
						1:       flen_w = FLEN_W'(eff + 1);
						default: flen_w = FLEN_W'(eff + $urandom_range(2, 24));
					endcase
				end
			endcase
			write_reg(REG_PREAMBLE_LEN, CFG_W'(plen_w));
			write_reg(REG_FRAME_LEN, CFG_W'(flen_w));
			write_reg(REG_PATTERN_LOW, (p == 8) ? '1 : {$urandom, $urandom});
			write_reg(REG_PATTERN_HIGH, (p == 8) ? '1 : {$urandom, $urandom});
			gaps_on = (p % 3) != 0;
			rx_mode = p % 4;
			stop_at = bytes_sent + 135;
			while (bytes_sent < stop_at) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_frame(1'b0);
				else if (pick < 9)
					repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
				else
					send_frame(1'b1);
			end
			settle();
		end
	endtask

	// receiver ready: free running, fixed pattern, random, or mostly stalled
	int unsigned rx_tick     = 0;
	int unsigned hold_left   = 0;
	int unsigned holds_taken = 0;
	always @(posedge clk) begin
		rx_tick++;
		if (holds_taken != holds_asked) begin
			holds_taken = holds_asked;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= RX_PATTERN[rx_tick % 16];
				2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compare each output beat with the oldest expected payload beat
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (payload_due.size() == 0) begin
				$error("unexpected beat: out_byte %h frame_end %b", m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = payload_due.pop_front();
				if (m_axis_tdata !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.frame_end) begin
					$error("frame_end: expected %b, got %b", want.frame_end, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_startup_fill();
		test_short_frames();
		test_output_hold();
		test_random_frames();
		settle();
		if (errors == 0)
			$display("[preamble_strip_framer_top] OK");
		else
			$display("[preamble_strip_framer_top] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#(4_000_000);
		$display("[preamble_strip_framer_top] ERROR");
		$finish;
	end

endmodule
